### rtl/superio_config_register_block_core_macros.svh
// ----------------------------------------------------------------------------
// superio config register block assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SUPERIO_CONFIG_REGISTER_BLOCK_CORE_MACROS_SVH
`define SUPERIO_CONFIG_REGISTER_BLOCK_CORE_MACROS_SVH

// same-cycle implication
`define SIO_CFG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIO_CFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sio_cfg_pkg.sv
// ----------------------------------------------------------------------------
// sio_cfg_pkg
// constants, types and reset tables of the super i/o configuration registers
// ----------------------------------------------------------------------------
package sio_cfg_pkg;

  localparam int NUM_DEVICES   = 10;
  localparam int GLB_REG_COUNT = 48;
  localparam int BANK_SIZE     = 256;

  localparam int DEV_W       = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int DEV_AW      = DEV_W + 8;
  localparam int DEV_DEPTH   = NUM_DEVICES * BANK_SIZE;
  localparam int DEV_RAM_AW  = $clog2(DEV_DEPTH);
  localparam int GLB_AW      = $clog2(GLB_REG_COUNT);

  // index port keys
  localparam logic [7:0] LOCK_KEY     = 8'h55;
  localparam logic [7:0] UNLOCK_KEY   = 8'hAA;
  localparam logic [7:0] IDLE_DATA    = 8'hFF;

  // global registers
  localparam logic [7:0] REG_DEV_SEL  = 8'h07;
  localparam logic [7:0] REG_ID0      = 8'h20;
  localparam logic [7:0] REG_ID1      = 8'h21;
  localparam logic [7:0] REG_DEV_EN   = 8'h22;

  // device registers
  localparam logic [7:0] REG_ACT      = 8'h30;
  localparam logic [7:0] REG_BASE_HI  = 8'h60;
  localparam logic [7:0] REG_BASE_LO  = 8'h61;
  localparam logic [7:0] REG_IRQ      = 8'h70;
  localparam logic [7:0] REG_FDC_OPT0 = 8'hF0;
  localparam logic [7:0] REG_FDC_OPT1 = 8'hF1;

  // logical devices
  localparam logic [7:0] DEV_FDC      = 8'd0;
  localparam logic [7:0] DEV_LPT      = 8'd3;
  localparam logic [7:0] DEV_COM1     = 8'd4;
  localparam logic [7:0] DEV_COM2     = 8'd5;

  // read source codes
  localparam logic [1:0] RSEL_NONE    = 2'd0;
  localparam logic [1:0] RSEL_GLB     = 2'd1;
  localparam logic [1:0] RSEL_DEV     = 2'd2;

  typedef struct packed {
    logic                  glb_en;
    logic                  glb_we;
    logic [GLB_AW-1:0]     glb_addr;
    logic [7:0]            glb_wdata;
    logic                  dev_en;
    logic                  dev_we;
    logic [DEV_RAM_AW-1:0] dev_addr;
    logic [7:0]            dev_wdata;
  } ram_req_t;

  typedef struct packed {
    logic cfg;
    logic floppy;
    logic busy;
  } ctrl_stat_t;

  // copies of the registers that feed the decode outputs
  typedef struct packed {
    logic [7:0] dev_sel;
    logic [3:0] glb_en;    // 0x22 bits 5,4,3,0
    logic [3:0] act;       // reg 0x30 bit0 of com2, com1, lpt, fdc
    logic [1:0] fdc_opt0;  // 0xf0 bits 4,0
    logic [1:0] fdc_opt1;  // 0xf1 bits 3:2
    logic [1:0] lpt_hi;
    logic [5:0] lpt_lo;
    logic [1:0] com1_hi;
    logic [4:0] com1_lo;
    logic [3:0] com1_irq;
    logic [1:0] com2_hi;
    logic [4:0] com2_lo;
    logic [3:0] com2_irq;
  } shadow_t;

  function automatic logic [7:0] glob_default(input logic [7:0] r);
    logic [7:0] v;
    v = 8'h00;
    case (r)
      8'h03:   v = 8'h03;
      8'h20:   v = 8'h03;
      8'h21:   v = 8'h01;
      8'h24:   v = 8'h04;
      8'h26:   v = 8'hF0;
      8'h27:   v = 8'h03;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dev_default(input logic [7:0] d, input logic [7:0] r);
    logic [7:0] v;
    v = 8'h00;
    case (d)
      8'd0: begin
        case (r)
          8'h60:   v = 8'h03;
          8'h61:   v = 8'hF0;
          8'h70:   v = 8'h06;
          8'h74:   v = 8'h02;
          8'hF0:   v = 8'h0E;
          8'hF2:   v = 8'hFF;
          default: v = 8'h00;
        endcase
      end
      8'd1: begin
        case (r)
          8'h60:   v = 8'h01;
          8'h61:   v = 8'hF0;
          8'h62:   v = 8'h03;
          8'h63:   v = 8'hF6;
          8'h70:   v = 8'h0E;
          8'hF0:   v = 8'h0C;
          8'hF1:   v = 8'h0D;
          default: v = 8'h00;
        endcase
      end
      8'd3: begin
        case (r)
          8'h74:   v = 8'h04;
          8'hF0:   v = 8'h3C;
          default: v = 8'h00;
        endcase
      end
      8'd5: begin
        case (r)
          8'h74:   v = 8'h04;
          8'hF1:   v = 8'h02;
          8'hF2:   v = 8'h03;
          default: v = 8'h00;
        endcase
      end
      8'd6: begin
        case (r)
          8'h63:   v = 8'h70;
          8'hF4:   v = 8'h03;
          default: v = 8'h00;
        endcase
      end
      8'd8: begin
        if (r == 8'hB1 || r == 8'hC9) begin
          v = 8'h80;
        end else if (r == 8'hC0 || r == 8'hC1) begin
          v = 8'h01;
        end else if (r >= 8'hC5 && r <= 8'hC8) begin
          v = 8'h01;
        end else if (r >= 8'hCB && r <= 8'hED) begin
          v = 8'h01;
        end
      end
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/sio_cfg_ram.sv
// ----------------------------------------------------------------------------
// sio_cfg_ram
// generic single-port ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module sio_cfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sio_cfg_ctrl.sv
// ----------------------------------------------------------------------------
// sio_cfg_ctrl
// lock sequence, register index, bank access requests, decode shadows and
// the post-reset pass that loads the register defaults into the rams
// ----------------------------------------------------------------------------
`include "superio_config_register_block_core_macros.svh"

module sio_cfg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic                   mode,
  input  logic                   port_select,
  input  logic [7:0]             write_data,
  output sio_cfg_pkg::ram_req_t  ram_req,
  output logic [1:0]             rsel,
  output sio_cfg_pkg::ctrl_stat_t stat,
  output sio_cfg_pkg::shadow_t   shd
);
  import sio_cfg_pkg::*;

  logic [7:0]        reg_index_r, reg_index_nxt;
  logic [7:0]        lock_older_r, lock_older_nxt;
  logic [7:0]        lock_newer_r, lock_newer_nxt;
  logic              floppy_r, floppy_nxt;
  shadow_t           shd_r, shd_nxt;
  logic              clr_busy_r, clr_busy_nxt;
  logic [DEV_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              cfg;
  logic              shift;
  logic              idx_wr;
  logic              data_wr;
  logic              data_rd;
  logic              glb_hit;
  logic              dev_ok;
  logic              glb_wr;
  logic              dev_wr;
  logic [DEV_AW-1:0] dev_full;

  assign cfg     = (lock_older_r == LOCK_KEY) && (lock_newer_r == LOCK_KEY);
  assign glb_hit = reg_index_r < 8'(GLB_REG_COUNT);
  assign dev_ok  = shd_r.dev_sel < 8'(NUM_DEVICES);

  assign shift   = acc && mode && !port_select && (!cfg || (write_data == UNLOCK_KEY));
  assign idx_wr  = acc && mode && !port_select && cfg && (write_data != UNLOCK_KEY);
  assign data_wr = acc && mode && port_select && cfg;
  assign data_rd = acc && !mode && port_select && cfg;

  assign glb_wr  = data_wr && glb_hit && (reg_index_r != REG_ID0) && (reg_index_r != REG_ID1);
  assign dev_wr  = data_wr && !glb_hit && dev_ok;

  assign dev_full = {shd_r.dev_sel[DEV_W-1:0], reg_index_r};

  always_comb begin
    if (data_rd && glb_hit) begin
      rsel = RSEL_GLB;
    end else if (data_rd && dev_ok) begin
      rsel = RSEL_DEV;
    end else begin
      rsel = RSEL_NONE;
    end
  end

  // lock pair, ownership of the data port and index
  always_comb begin
    reg_index_nxt  = reg_index_r;
    lock_older_nxt = lock_older_r;
    lock_newer_nxt = lock_newer_r;
    floppy_nxt     = floppy_r;
    if (shift) begin
      if ((write_data == LOCK_KEY) && (lock_newer_r == LOCK_KEY)) begin
        floppy_nxt = 1'b0;
      end
      if (cfg && (write_data != LOCK_KEY)) begin
        floppy_nxt = 1'b1;
      end
      lock_older_nxt = lock_newer_r;
      lock_newer_nxt = write_data;
    end
    if (idx_wr) begin
      reg_index_nxt = write_data;
    end
  end

  always_comb begin
    shd_nxt = shd_r;
    if (glb_wr && (reg_index_r == REG_DEV_SEL)) begin
      shd_nxt.dev_sel = write_data;
    end
    if (glb_wr && (reg_index_r == REG_DEV_EN)) begin
      shd_nxt.glb_en = {write_data[5], write_data[4], write_data[3], write_data[0]};
    end
    if (dev_wr) begin
      case (shd_r.dev_sel)
        DEV_FDC: begin
          if (reg_index_r == REG_ACT)      shd_nxt.act[0]   = write_data[0];
          if (reg_index_r == REG_FDC_OPT0) shd_nxt.fdc_opt0 = {write_data[4], write_data[0]};
          if (reg_index_r == REG_FDC_OPT1) shd_nxt.fdc_opt1 = write_data[3:2];
        end
        DEV_LPT: begin
          if (reg_index_r == REG_ACT)      shd_nxt.act[1]   = write_data[0];
          if (reg_index_r == REG_BASE_HI)  shd_nxt.lpt_hi   = write_data[1:0];
          if (reg_index_r == REG_BASE_LO)  shd_nxt.lpt_lo   = write_data[7:2];
        end
        DEV_COM1: begin
          if (reg_index_r == REG_ACT)      shd_nxt.act[2]   = write_data[0];
          if (reg_index_r == REG_BASE_HI)  shd_nxt.com1_hi  = write_data[1:0];
          if (reg_index_r == REG_BASE_LO)  shd_nxt.com1_lo  = write_data[7:3];
          if (reg_index_r == REG_IRQ)      shd_nxt.com1_irq = write_data[3:0];
        end
        DEV_COM2: begin
          if (reg_index_r == REG_ACT)      shd_nxt.act[3]   = write_data[0];
          if (reg_index_r == REG_BASE_HI)  shd_nxt.com2_hi  = write_data[1:0];
          if (reg_index_r == REG_BASE_LO)  shd_nxt.com2_lo  = write_data[7:3];
          if (reg_index_r == REG_IRQ)      shd_nxt.com2_irq = write_data[3:0];
        end
        default: begin
          shd_nxt = shd_r;
        end
      endcase
    end
  end

  // default load sweep, one device entry per cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == DEV_AW'(DEV_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_req.glb_en    = clr_cnt_r < DEV_AW'(GLB_REG_COUNT);
      ram_req.glb_we    = 1'b1;
      ram_req.glb_addr  = clr_cnt_r[GLB_AW-1:0];
      ram_req.glb_wdata = glob_default(8'(clr_cnt_r[GLB_AW-1:0]));
      ram_req.dev_en    = 1'b1;
      ram_req.dev_we    = 1'b1;
      ram_req.dev_addr  = clr_cnt_r[DEV_RAM_AW-1:0];
      ram_req.dev_wdata = dev_default(8'(clr_cnt_r[DEV_AW-1:8]), clr_cnt_r[7:0]);
    end else begin
      ram_req.glb_en    = glb_wr || (rsel == RSEL_GLB);
      ram_req.glb_we    = glb_wr;
      ram_req.glb_addr  = reg_index_r[GLB_AW-1:0];
      ram_req.glb_wdata = write_data;
      ram_req.dev_en    = dev_wr || (rsel == RSEL_DEV);
      ram_req.dev_we    = dev_wr;
      ram_req.dev_addr  = dev_full[DEV_RAM_AW-1:0];
      ram_req.dev_wdata = write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_index_r  <= '0;
      lock_older_r <= '0;
      lock_newer_r <= '0;
      floppy_r     <= 1'b1;
      shd_r        <= '0;
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      reg_index_r  <= reg_index_nxt;
      lock_older_r <= lock_older_nxt;
      lock_newer_r <= lock_newer_nxt;
      floppy_r     <= floppy_nxt;
      shd_r        <= shd_nxt;
      clr_busy_r   <= clr_busy_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  assign stat.cfg    = cfg;
  assign stat.floppy = floppy_r;
  assign stat.busy   = clr_busy_r;
  assign shd         = shd_r;

  `SIO_CFG_ASSERT_IMPLIES(a_floppy_fall_cfg, $fell(floppy_r), cfg, "floppy lost port outside config")
  `SIO_CFG_ASSERT_IMPLIES(a_cfg_rise_floppy, $rose(cfg), !floppy_r, "config entered, floppy still owns port")
  `SIO_CFG_ASSERT_IMPLIES(a_sweep_end, $fell(clr_busy_r), $past(clr_cnt_r) == DEV_AW'(DEV_DEPTH - 1), "default sweep ended early")

endmodule

### rtl/superio_config_register_block_core.sv
// ----------------------------------------------------------------------------
// superio_config_register_block_core
// super i/o configuration registers behind an index/data port pair, with
// registered decodes of the device enables, bases, irqs and floppy options
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | mode, port_select, write_data
//  out     | output    | out_valid / out_stall | read_data, in_config, decodes
//
//  one request per cycle sustained while in_stall is low; out_valid rises when
//  the output register loads, after the bank ram read registered at the accepting edge
//  after reset a sweep loads register defaults into the global and device bank rams,
//  one entry per cycle, with in_stall held high
//  out_stall holds the output register; one more request waits behind it
//  before in_stall rises
// ----------------------------------------------------------------------------
`include "superio_config_register_block_core_macros.svh"

module superio_config_register_block_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic       in_port_select,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_in_config,
  output logic       out_floppy_owns_data_port,
  output logic [3:0] out_device_enables,
  output logic [9:0] out_parallel_base,
  output logic [9:0] out_serial1_base,
  output logic [3:0] out_serial1_irq,
  output logic [9:0] out_serial2_base,
  output logic [3:0] out_serial2_irq,
  output logic [3:0] out_floppy_options
);
  import sio_cfg_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       in_config;
    logic       floppy;
    logic [3:0] enables;
    logic [9:0] lpt_base;
    logic [9:0] com1_base;
    logic [3:0] com1_irq;
    logic [9:0] com2_base;
    logic [3:0] com2_irq;
    logic [3:0] fdc_opts;
  } res_t;

  ram_req_t   ram_req;
  logic [1:0] rsel;
  ctrl_stat_t stat;
  shadow_t    shd;
  logic [7:0] glb_q;
  logic [7:0] dev_q;

  logic       in_acc;
  logic       adv;
  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_rsel_r, s1_rsel_nxt;
  logic       out_v_r, out_v_nxt;
  res_t       res_r, res_nxt;
  logic [7:0] rd_mux;

  assign in_stall = stat.busy || (s1_v_r && out_v_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = s1_v_r && (!out_v_r || !out_stall);

  sio_cfg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .mode        (in_mode),
    .port_select (in_port_select),
    .write_data  (in_write_data),
    .ram_req     (ram_req),
    .rsel        (rsel),
    .stat        (stat),
    .shd         (shd)
  );

  sio_cfg_ram #(
    .WIDTH (8),
    .DEPTH (GLB_REG_COUNT)
  ) u_glb_ram (
    .clk   (clk),
    .en    (ram_req.glb_en),
    .we    (ram_req.glb_we),
    .addr  (ram_req.glb_addr),
    .wdata (ram_req.glb_wdata),
    .rdata (glb_q)
  );

  sio_cfg_ram #(
    .WIDTH (8),
    .DEPTH (DEV_DEPTH)
  ) u_dev_ram (
    .clk   (clk),
    .en    (ram_req.dev_en),
    .we    (ram_req.dev_we),
    .addr  (ram_req.dev_addr),
    .wdata (ram_req.dev_wdata),
    .rdata (dev_q)
  );

  always_comb begin
    case (s1_rsel_r)
      RSEL_GLB: rd_mux = glb_q;
      RSEL_DEV: rd_mux = dev_q;
      default:  rd_mux = IDLE_DATA;
    endcase
  end

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_rsel_nxt = s1_rsel_r;
    out_v_nxt   = out_v_r;
    res_nxt     = res_r;
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (adv) begin
      s1_v_nxt          = 1'b0;
      out_v_nxt         = 1'b1;
      // state registers hold the post-request values until the next request
      res_nxt.read_data = rd_mux;
      res_nxt.in_config = stat.cfg;
      res_nxt.floppy    = stat.floppy;
      res_nxt.enables   = shd.glb_en & shd.act;
      res_nxt.lpt_base  = {shd.lpt_hi, shd.lpt_lo, 2'b00};
      res_nxt.com1_base = {shd.com1_hi, shd.com1_lo, 3'b000};
      res_nxt.com1_irq  = shd.com1_irq;
      res_nxt.com2_base = {shd.com2_hi, shd.com2_lo, 3'b000};
      res_nxt.com2_irq  = shd.com2_irq;
      res_nxt.fdc_opts  = {shd.fdc_opt0[1], shd.fdc_opt1, shd.fdc_opt0[0]};
    end
    if (in_acc) begin
      s1_v_nxt    = 1'b1;
      s1_rsel_nxt = rsel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_rsel_r <= s1_rsel_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid                 = out_v_r;
  assign out_read_data             = res_r.read_data;
  assign out_in_config             = res_r.in_config;
  assign out_floppy_owns_data_port = res_r.floppy;
  assign out_device_enables        = res_r.enables;
  assign out_parallel_base         = res_r.lpt_base;
  assign out_serial1_base          = res_r.com1_base;
  assign out_serial1_irq           = res_r.com1_irq;
  assign out_serial2_base          = res_r.com2_base;
  assign out_serial2_irq           = res_r.com2_irq;
  assign out_floppy_options        = res_r.fdc_opts;

  `SIO_CFG_ASSERT_IMPLIES(a_s1_no_overwrite, s1_v_r && !adv, !in_acc, "pending request overwritten")
  `SIO_CFG_ASSERT_IMPLIES(a_rd_needs_cfg, s1_v_r && (s1_rsel_r != RSEL_NONE), stat.cfg, "bank read outside config mode")
  `SIO_CFG_ASSERT_IMPLIES(a_sweep_empty, stat.busy, !s1_v_r && !out_v_r, "request in flight during default sweep")

endmodule
